// ----- design/humidity_temp_frame_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder. Clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, off during reset
`define HTFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("htfd check failed");

// Next-cycle implication, off during reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("htfd check failed");

`endif

// ----- design/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 20;
    localparam int PAYLOAD_W = 40;
    localparam int HUM_T_W   = 10;
    localparam int TMP_T_W   = 12;
    localparam int ERRCNT_W  = 16;
    localparam int POS_W     = 3;

    // Consecutive-fault counter width (4..32)
    localparam int ERROR_COUNT_BITS = 16;

    // CRC-8, poly 0x31, init 0xFF, MSB first
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Frame layout
    localparam logic [POS_W-1:0] POS_STATUS      = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST_DATA   = 3'd5;
    localparam logic [POS_W:0]   LEN_CHECKED     = 4'd7;
    localparam logic [POS_W:0]   LEN_UNCHECKED   = 4'd6;

    // Conversion constants
    localparam logic [9:0]          HUM_SCALE  = 10'd1000;
    localparam logic [10:0]         TMP_SCALE  = 11'd2000;
    localparam logic [TMP_T_W-1:0]  TMP_OFFSET = 12'd500;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_CRC_CHECK_ENABLE = 1'b0;

    // Frame event handed from the byte tracker to the converter
    typedef struct packed {
        logic [BYTE_W-1:0] status_value;
        logic [RAW_W-1:0]  humidity_raw;
        logic [RAW_W-1:0]  temperature_raw;
        logic              crc_error;
    } t_frame_evt;

    // Result beat
    typedef struct packed {
        logic [BYTE_W-1:0]         status_value;
        logic [RAW_W-1:0]          humidity_raw;
        logic [RAW_W-1:0]          temperature_raw;
        logic [HUM_T_W-1:0]        humidity_tenths;
        logic signed [TMP_T_W-1:0] temperature_tenths;
        logic                      crc_error;
        logic                      reading_fault;
        logic [ERRCNT_W-1:0]       error_count;
    } t_result;

    // One byte through the CRC, bit by bit
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- design/htfd_in_if.sv -----
// ----------------------------------------------------------------------------
// htfd_in_if
// Byte channel into the decoder: one reply byte per beat.
// ----------------------------------------------------------------------------
interface htfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [htfd_pkg::BYTE_W-1:0]   data_byte;
    logic                          frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- design/htfd_out_if.sv -----
// ----------------------------------------------------------------------------
// htfd_out_if
// Result channel out of the decoder: one decoded frame per beat.
// ----------------------------------------------------------------------------
interface htfd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [htfd_pkg::BYTE_W-1:0]           status_value;
    logic [htfd_pkg::RAW_W-1:0]            humidity_raw;
    logic [htfd_pkg::RAW_W-1:0]            temperature_raw;
    logic [htfd_pkg::HUM_T_W-1:0]          humidity_tenths;
    logic signed [htfd_pkg::TMP_T_W-1:0]   temperature_tenths;
    logic                                  crc_error;
    logic                                  reading_fault;
    logic [htfd_pkg::ERRCNT_W-1:0]         error_count;

    modport source (output valid, output status_value, output humidity_raw,
                    output temperature_raw, output humidity_tenths,
                    output temperature_tenths, output crc_error,
                    output reading_fault, output error_count, input ready);
    modport sink   (input valid, input status_value, input humidity_raw,
                    input temperature_raw, input humidity_tenths,
                    input temperature_tenths, input crc_error,
                    input reading_fault, input error_count, output ready);
endinterface

// ----- design/htfd_cfg.sv -----
// ----------------------------------------------------------------------------
// htfd_cfg
// APB register block: holds the CRC check enable.
// ----------------------------------------------------------------------------
module htfd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [htfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [htfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              o_crc_check_enable
);

    logic r_crc_check_enable;
    logic n_crc_check_enable;
    logic w_sel_crc;

    // Word decode, byte lanes ignored
    assign w_sel_crc = (paddr[htfd_pkg::APB_ADDR_W-1:2] == htfd_pkg::REG_CRC_CHECK_ENABLE);
    assign pready    = 1'b1;

    // Write on the access phase
    always_comb begin
        n_crc_check_enable = r_crc_check_enable;
        if (psel && penable && pwrite && pready && w_sel_crc) begin
            n_crc_check_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_check_enable <= 1'b1;
        end else begin
            r_crc_check_enable <= n_crc_check_enable;
        end
    end

    // Read back
    assign prdata = w_sel_crc ? htfd_pkg::APB_DATA_W'(r_crc_check_enable)
                              : '0;
    assign o_crc_check_enable = r_crc_check_enable;

endmodule

// ----- design/htfd_frame.sv -----
// ----------------------------------------------------------------------------
// htfd_frame
// Byte tracker: frame position, running CRC and payload assembly. Registers
// one frame event on the last byte of a frame.
// ----------------------------------------------------------------------------
module htfd_frame (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [htfd_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_frame_start,
    input  logic                           i_crc_check_enable,
    output logic                           o_ready,
    output logic                           o_evt_valid,
    output htfd_pkg::t_frame_evt           o_evt,
    input  logic                           i_evt_ready
);

    logic [htfd_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [htfd_pkg::BYTE_W-1:0]    r_crc, n_crc;
    logic [htfd_pkg::BYTE_W-1:0]    r_status, n_status;
    logic [htfd_pkg::PAYLOAD_W-1:0] r_payload, n_payload;
    logic                           r_evt_valid, n_evt_valid;
    htfd_pkg::t_frame_evt           r_evt, n_evt;

    logic                           w_accept;
    logic                           w_active;
    logic                           w_last;
    logic                           w_crc_err;
    logic [htfd_pkg::POS_W-1:0]     w_pos;
    logic [htfd_pkg::POS_W:0]       w_count;
    logic [htfd_pkg::POS_W:0]       w_len;
    logic [htfd_pkg::BYTE_W-1:0]    w_crc_base;
    logic [htfd_pkg::PAYLOAD_W-1:0] w_payload_base;

    // Event slot free or draining this cycle
    assign o_ready  = !r_evt_valid || i_evt_ready;
    assign w_accept = i_valid && o_ready;

    // Start mark reopens the frame; a stray byte outside a frame is dropped
    assign w_active       = i_frame_start || (r_pos != htfd_pkg::POS_STATUS);
    assign w_pos          = i_frame_start ? htfd_pkg::POS_STATUS : r_pos;
    assign w_crc_base     = i_frame_start ? htfd_pkg::CRC_INIT : r_crc;
    assign w_payload_base = i_frame_start ? '0 : r_payload;
    assign w_count        = {1'b0, w_pos} + 1'b1;
    assign w_len          = i_crc_check_enable ? htfd_pkg::LEN_CHECKED
                                               : htfd_pkg::LEN_UNCHECKED;
    assign w_last         = (w_count >= w_len);

    // Byte step
    always_comb begin
        n_status  = r_status;
        n_payload = w_payload_base;
        n_crc     = w_crc_base;
        w_crc_err = 1'b0;
        if (w_pos == htfd_pkg::POS_STATUS) begin
            n_status = i_data_byte;
            n_crc    = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, i_data_byte);
        end else if (w_pos <= htfd_pkg::POS_LAST_DATA) begin
            n_payload = {w_payload_base[htfd_pkg::PAYLOAD_W-htfd_pkg::BYTE_W-1:0],
                         i_data_byte};
            n_crc     = htfd_pkg::crc8_byte(w_crc_base, i_data_byte);
        end else begin
            w_crc_err = i_crc_check_enable && (i_data_byte != w_crc_base);
        end
    end

    // Frame event
    always_comb begin
        n_evt.status_value    = n_status;
        n_evt.crc_error       = w_crc_err;
        n_evt.humidity_raw    = w_crc_err ? '0
            : n_payload[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W];
        n_evt.temperature_raw = w_crc_err ? '0 : n_payload[htfd_pkg::RAW_W-1:0];
    end

    // Position and event slot control
    always_comb begin
        n_pos       = r_pos;
        n_evt_valid = r_evt_valid && !i_evt_ready;
        if (w_accept && w_active) begin
            if (w_last) begin
                n_pos       = htfd_pkg::POS_STATUS;
                n_evt_valid = 1'b1;
            end else begin
                n_pos = w_count[htfd_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= htfd_pkg::POS_STATUS;
            r_crc       <= htfd_pkg::CRC_INIT;
            r_evt_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_evt_valid <= n_evt_valid;
            if (w_accept && w_active) begin
                r_crc <= w_last ? htfd_pkg::CRC_INIT : n_crc;
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge i_clk) begin
        if (w_accept && w_active) begin
            r_status  <= n_status;
            r_payload <= n_payload;
            if (w_last) begin
                r_evt <= n_evt;
            end
        end
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

endmodule

// ----- design/htfd_convert.sv -----
// ----------------------------------------------------------------------------
// htfd_convert
// Converter: fault check, consecutive-fault counter and scaling to tenths.
// Drives the registered result beat.
// ----------------------------------------------------------------------------
module htfd_convert (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_evt_valid,
    input  htfd_pkg::t_frame_evt    i_evt,
    output logic                    o_evt_ready,
    output logic                    o_res_valid,
    output htfd_pkg::t_result       o_res,
    input  logic                    i_res_ready
);

    logic [htfd_pkg::ERROR_COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                                  r_res_valid, n_res_valid;
    htfd_pkg::t_result                     r_res, n_res;

    logic                                  w_take;
    logic                                  w_fault;
    logic [29:0]                           w_hum_mul;
    logic [30:0]                           w_tmp_mul;
    logic [31:0]                           w_cnt_ext;

    assign o_evt_ready = !r_res_valid || i_res_ready;
    assign w_take      = i_evt_valid && o_evt_ready;

    // Scaling: raw * k >> 20
    assign w_hum_mul = 30'(i_evt.humidity_raw) * 30'(htfd_pkg::HUM_SCALE);
    assign w_tmp_mul = 31'(i_evt.temperature_raw) * 31'(htfd_pkg::TMP_SCALE);
    assign w_fault   = (i_evt.humidity_raw == '0) && (i_evt.temperature_raw == '0);

    // Counter counts faults, a good frame clears it
    assign n_cnt     = w_fault ? r_cnt + 1'b1 : '0;
    assign w_cnt_ext = 32'(n_cnt);

    // Result beat
    always_comb begin
        n_res.status_value       = i_evt.status_value;
        n_res.humidity_raw       = i_evt.humidity_raw;
        n_res.temperature_raw    = i_evt.temperature_raw;
        n_res.crc_error          = i_evt.crc_error;
        n_res.reading_fault      = w_fault;
        n_res.error_count        = w_cnt_ext[htfd_pkg::ERRCNT_W-1:0];
        n_res.humidity_tenths    = '0;
        n_res.temperature_tenths = '0;
        if (!w_fault) begin
            n_res.humidity_tenths    = w_hum_mul[29:20];
            n_res.temperature_tenths = htfd_pkg::TMP_T_W'(w_tmp_mul[30:20])
                                       - htfd_pkg::TMP_OFFSET;
        end
    end

    always_comb begin
        n_res_valid = r_res_valid && !i_res_ready;
        if (w_take) begin
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            if (w_take) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- design/humidity_temp_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes a humidity/temperature sensor reply, checks its CRC-8 and scales
// the readings to tenths.
//
//   Channel   Dir  Beat                      Handshake
//   i_in      in   one reply byte            valid/ready
//   o_out     out  one decoded frame         valid/ready
//   APB       in   crc_check_enable write    psel/penable/pwrite, pready = 1
//
// One byte per cycle sustained while the result side is not stalled; the result
// of a frame passes through the tracker event register, then the result register.
// Synchronous active-low reset: no frame open, CRC at 0xFF, check enabled,
// fault counter zero. A stalled result holds; the byte side keeps taking
// bytes until both the event and result registers are full.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_macros.svh"

module humidity_temp_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    htfd_in_if.sink                           i_in,
    htfd_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [htfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [htfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                  w_crc_check_enable;
    logic                  w_evt_valid;
    logic                  w_evt_ready;
    htfd_pkg::t_frame_evt  w_evt;
    logic                  w_res_valid;
    htfd_pkg::t_result     w_res;

    // Register block
    htfd_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_crc_check_enable (w_crc_check_enable)
    );

    // Byte tracker
    htfd_frame u_frame (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in.valid),
        .i_data_byte        (i_in.data_byte),
        .i_frame_start      (i_in.frame_start),
        .i_crc_check_enable (w_crc_check_enable),
        .o_ready            (i_in.ready),
        .o_evt_valid        (w_evt_valid),
        .o_evt              (w_evt),
        .i_evt_ready        (w_evt_ready)
    );

    // Converter
    htfd_convert u_convert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (w_evt_valid),
        .i_evt       (w_evt),
        .o_evt_ready (w_evt_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (o_out.ready)
    );

    // Result beat onto the channel
    assign o_out.valid              = w_res_valid;
    assign o_out.status_value       = w_res.status_value;
    assign o_out.humidity_raw       = w_res.humidity_raw;
    assign o_out.temperature_raw    = w_res.temperature_raw;
    assign o_out.humidity_tenths    = w_res.humidity_tenths;
    assign o_out.temperature_tenths = w_res.temperature_tenths;
    assign o_out.crc_error          = w_res.crc_error;
    assign o_out.reading_fault      = w_res.reading_fault;
    assign o_out.error_count        = w_res.error_count;

    // Checks
    `HTFD_ASSERT_IMP(a_crc_err_zeroes, o_out.valid && o_out.crc_error, o_out.humidity_raw == '0 && o_out.temperature_raw == '0 && o_out.reading_fault)
    `HTFD_ASSERT_IMP(a_fault_no_tenths, o_out.valid && o_out.reading_fault, o_out.humidity_tenths == '0 && o_out.temperature_tenths == '0)
    `HTFD_ASSERT_IMP(a_good_clears_cnt, o_out.valid && !o_out.reading_fault, o_out.error_count == '0)
    `HTFD_ASSERT_NEXT(a_start_no_event, i_in.valid && i_in.ready && i_in.frame_start, !w_evt_valid)

endmodule

// ----- verif/tb_humidity_temp_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder
// Self-checking bench for the humidity/temperature frame decoder. Reply bytes
// are pushed through the byte channel and every accepted byte is run through
// a local decoder that tracks frame position, CRC-8 and the fault counter and
// queues the decoded frame it expects. Each result beat is checked field by
// field against the oldest queued frame. The CRC check enable is toggled over
// APB between phases, including with a frame half received.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    // Result passes the tracker event and result registers after the closing byte
    localparam int RESULT_LATENCY  = 2;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_ITEMS    = 1300;
    localparam int RANDOM_PHASES   = 6;
    localparam logic [APB_ADDR_W-1:0] CHECK_ENABLE_ADDR =
        APB_ADDR_W'(4 * int'(REG_CRC_CHECK_ENABLE));

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    htfd_in_if  in_ch ();
    htfd_out_if out_ch ();

    humidity_temp_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the decoder state
    logic                        chk_enabled = 1'b1;
    logic [POS_W-1:0]            frame_pos   = '0;
    logic [BYTE_W-1:0]           crc_acc     = CRC_INIT;
    logic [BYTE_W-1:0]           status_byte = '0;
    logic [PAYLOAD_W-1:0]        payload_bits = '0;
    logic [ERROR_COUNT_BITS-1:0] fault_run   = '0;

    t_result     pending_readings[$];
    int unsigned bytes_taken    = 0;
    int unsigned mismatch_count = 0;
    logic        no_gaps        = 1'b0;
    logic        hold_off_request = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One byte through CRC-8, poly 0x31, MSB first
    function automatic logic [BYTE_W-1:0] crc31_step(input logic [BYTE_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = acc ^ b;
        repeat (BYTE_W) r = r[BYTE_W-1] ? ({r[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
                                        : {r[BYTE_W-2:0], 1'b0};
        return r;
    endfunction

    // Decode one accepted byte; returns 0 when the byte is ignored
    function automatic logic decode_reply_byte(input logic [BYTE_W-1:0] b,
                                               input logic start);
        logic [POS_W:0]     next_pos;
        logic [POS_W:0]     frame_len;
        logic [RAW_W-1:0]   hum;
        logic [RAW_W-1:0]   tmp;
        logic [63:0]        wide;
        logic               crc_bad;
        t_result            r;
        crc_bad = 1'b0;
        if (start) begin
            frame_pos    = '0;
            crc_acc      = CRC_INIT;
            payload_bits = '0;
        end else if (frame_pos == POS_STATUS) begin
            return 1'b0;
        end

        if (frame_pos == POS_STATUS) begin
            status_byte = b;
            crc_acc     = crc31_step(CRC_INIT, b);
        end else if (frame_pos <= POS_LAST_DATA) begin
            payload_bits = {payload_bits[PAYLOAD_W-BYTE_W-1:0], b};
            crc_acc      = crc31_step(crc_acc, b);
        end else if (chk_enabled) begin
            crc_bad = (b != crc_acc);
        end

        next_pos  = {1'b0, frame_pos} + 1'b1;
        frame_len = chk_enabled ? LEN_CHECKED : LEN_UNCHECKED;
        if (next_pos < frame_len) begin
            frame_pos = next_pos[POS_W-1:0];
            return 1'b1;
        end

        // Frame closes here
        hum = crc_bad ? '0 : payload_bits[PAYLOAD_W-1:RAW_W];
        tmp = crc_bad ? '0 : payload_bits[RAW_W-1:0];
        r.status_value    = status_byte;
        r.humidity_raw    = hum;
        r.temperature_raw = tmp;
        r.crc_error       = crc_bad;
        r.reading_fault   = (hum == '0) && (tmp == '0);
        if (r.reading_fault) begin
            fault_run            = fault_run + 1'b1;
            r.humidity_tenths    = '0;
            r.temperature_tenths = '0;
        end else begin
            fault_run            = '0;
            wide                 = 64'(hum) * 64'd1000;
            r.humidity_tenths    = HUM_T_W'(wide >> RAW_W);
            wide                 = 64'(tmp) * 64'd2000;
            r.temperature_tenths = TMP_T_W'((wide >> RAW_W) - 64'd500);
        end
        r.error_count = ERRCNT_W'(fault_run);
        pending_readings.push_back(r);
        frame_pos = '0;
        crc_acc   = CRC_INIT;
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Send one byte; gaps before it at random. Starts and ends on a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        while (!no_gaps && $urandom_range(99) < 32) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.data_byte   = b;
        in_ch.frame_start = start;
        do @(posedge i_clk); while (!in_ch.ready);
        if (decode_reply_byte(b, start))
            bytes_taken++;
        @(negedge i_clk);
    endtask

    // Whole frame; CRC byte only when the check is on, optionally corrupted
    task automatic send_frame(input logic [BYTE_W-1:0] status,
                              input logic [PAYLOAD_W-1:0] payload, input logic corrupt);
        logic [BYTE_W-1:0] acc;
        acc = crc31_step(CRC_INIT, status);
        send_byte(status, 1'b1);
        for (int i = PAYLOAD_W / BYTE_W - 1; i >= 0; i--) begin
            acc = crc31_step(acc, payload[BYTE_W*i +: BYTE_W]);
            send_byte(payload[BYTE_W*i +: BYTE_W], 1'b0);
        end
        if (chk_enabled)
            send_byte(corrupt ? acc ^ BYTE_W'($urandom_range(1, 255)) : acc, 1'b0);
    endtask

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {RAW_W'(0), RAW_W'($urandom)};
            3:       return {RAW_W'($urandom), RAW_W'(0)};
            4:       return {RAW_W'($urandom_range(3)), RAW_W'($urandom_range(3))};
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Lower valid and let every expected frame come back, then settle
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB setup then access phase
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_crc_check(input logic en);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        apb_access(1'b1, CHECK_ENABLE_ADDR, APB_DATA_W'(en), rd);
        chk_enabled = en;
        apb_access(1'b0, CHECK_ENABLE_ADDR, '0, rd);
        compare_field("crc_check_enable", 64'(en), 64'(rd));
    endtask

    // Extremes, fault, CRC error, stray byte, start mark mid-frame
    task automatic test_directed_frames();
        send_byte(8'hA5, 1'b0);
        send_frame(8'hFF, '1, 1'b0);
        send_frame(8'h00, '0, 1'b0);
        send_byte(8'h1C, 1'b1);
        send_byte(8'h55, 1'b0);
        send_frame(8'h18, 40'h12345_6789A, 1'b1);
    endtask

    // Register reset value, unchecked frames and toggling with a frame open
    task automatic test_check_setting();
        logic [APB_DATA_W-1:0] rd;
        logic [BYTE_W-1:0]     acc;
        logic [BYTE_W-1:0]     b;
        wait_idle();
        apb_access(1'b0, CHECK_ENABLE_ADDR, '0, rd);
        compare_field("crc_check_enable", 64'd1, 64'(rd));

        // six-byte frame, lowest non-zero temperature
        set_crc_check(1'b0);
        send_frame(8'h08, {RAW_W'(0), RAW_W'(1)}, 1'b0);

        // six bytes in with check on, then off: next byte closes unchecked
        set_crc_check(1'b1);
        send_byte(8'h1C, 1'b1);
        repeat (5) send_byte(8'($urandom), 1'b0);
        set_crc_check(1'b0);
        send_byte(8'hEE, 1'b0);

        // five bytes in with check off, then on: frame runs to seven bytes
        b   = 8'($urandom);
        acc = crc31_step(CRC_INIT, b);
        send_byte(b, 1'b1);
        repeat (4) begin
            b   = 8'($urandom);
            acc = crc31_step(acc, b);
            send_byte(b, 1'b0);
        end
        set_crc_check(1'b1);
        b   = 8'($urandom);
        acc = crc31_step(acc, b);
        send_byte(b, 1'b0);
        send_byte(acc, 1'b0);
    endtask

    // Receiver holds off long enough to back up the byte side
    task automatic test_output_stall();
        wait_idle();
        hold_off_request = 1'b1;
        no_gaps          = 1'b1;
        repeat (10) send_frame(8'($urandom), pick_payload(), 1'b0);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // Mostly well-formed frames, some corrupt, truncated or stray bytes
    task automatic test_random_traffic();
        int unsigned phase_start;
        int unsigned pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_crc_check(phase % 3 != 1);
            no_gaps     = (phase == 2);
            phase_start = bytes_taken;
            while (bytes_taken - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    send_frame(8'($urandom), pick_payload(), 1'b0);
                end else if (pick < 88) begin
                    send_frame(8'($urandom), pick_payload(), chk_enabled);
                end else if (pick < 95) begin
                    send_byte(8'($urandom), 1'b1);
                    repeat ($urandom_range(0, chk_enabled ? 5 : 4))
                        send_byte(8'($urandom), 1'b0);
                end else begin
                    send_byte(8'($urandom), 1'b0);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result receiver: random ready, long hold-off on request
    initial begin : result_ready
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_request = 1'b0;
            end
            out_ch.ready = no_gaps || ($urandom_range(99) >= 32);
        end
    end

    // Result check against the oldest expected frame
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with no frame pending, status %0d",
                       out_ch.status_value);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                compare_field("status_value", 64'(want.status_value),
                              64'(out_ch.status_value));
                compare_field("humidity_raw", 64'(want.humidity_raw),
                              64'(out_ch.humidity_raw));
                compare_field("temperature_raw", 64'(want.temperature_raw),
                              64'(out_ch.temperature_raw));
                compare_field("humidity_tenths", 64'(want.humidity_tenths),
                              64'(out_ch.humidity_tenths));
                compare_field("temperature_tenths", 64'(want.temperature_tenths),
                              64'(out_ch.temperature_tenths));
                compare_field("crc_error", 64'(want.crc_error),
                              64'(out_ch.crc_error));
                compare_field("reading_fault", 64'(want.reading_fault),
                              64'(out_ch.reading_fault));
                compare_field("error_count", 64'(want.error_count),
                              64'(out_ch.error_count));
            end
        end
    end

    // Main sequence
    initial begin : main_seq
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.frame_start = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_frames();
        test_check_setting();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        repeat (RESULT_LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("tb_humidity_temp_frame_decoder OK");
        end else begin
            $display("tb_humidity_temp_frame_decoder NOT OK");
        end
        $finish;
    end

    // Hard stop
    initial begin : run_limit
        #2ms;
        $display("tb_humidity_temp_frame_decoder NOT OK");
        $finish;
    end

endmodule
